@@ rtl/sync_frame_parser_sum_check_macros.svh @@
// assertion macros for the frame parser
`ifndef SYNC_FRAME_PARSER_SUM_CHECK_MACROS_SVH
`define SYNC_FRAME_PARSER_SUM_CHECK_MACROS_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define SFPSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sfpsc assertion failed");
// checked at every edge, reset included
`define SFPSC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sfpsc assertion failed");
`else
`define SFPSC_ASSERT(lbl, prop)
`define SFPSC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/sfpsc_pkg.sv @@
// constants and phase codes of the frame parser
`default_nettype none

package sfpsc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 3;

  localparam logic [ByteW-1:0] SyncA        = 8'hFF;
  localparam logic [ByteW-1:0] SyncB        = 8'h55;
  localparam logic [ByteW-1:0] SyncC        = 8'hAA;
  localparam int unsigned      NoPayloadBit = 7;

  localparam logic [PhaseW-1:0] PH_HUNT   = 3'd0;
  localparam logic [PhaseW-1:0] PH_SYNC_B = 3'd1;
  localparam logic [PhaseW-1:0] PH_SYNC_C = 3'd2;
  localparam logic [PhaseW-1:0] PH_LEN    = 3'd3;
  localparam logic [PhaseW-1:0] PH_TYPE   = 3'd4;
  localparam logic [PhaseW-1:0] PH_DATA   = 3'd5;
  localparam logic [PhaseW-1:0] PH_SUM    = 3'd6;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

endpackage

`default_nettype wire

@@ rtl/sfpsc_if.sv @@
// valid/ready channels of the frame parser
`default_nettype none

interface sfpsc_rx_if import sfpsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfpsc_res_if import sfpsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [ByteW-1:0] frame_type;
  logic [ByteW-1:0] payload_byte;
  logic [ByteW-1:0] payload_index;
  logic [ByteW-1:0] payload_count;
  logic             checksum_ok;

  modport source (output valid, output result_kind, output frame_type, output payload_byte,
                  output payload_index, output payload_count, output checksum_ok,
                  input ready);
  modport sink (input valid, input result_kind, input frame_type, input payload_byte,
                input payload_index, input payload_count, input checksum_ok,
                output ready);
endinterface

`default_nettype wire

@@ rtl/sync_frame_parser_sum_check.sv @@
// serial frame parser: sync hunt, length/type/payload, additive checksum verdict
//
//   channel  dir  handshake            payload
//   rx_i     in   valid/ready          rx_byte
//   res_o    out  valid/ready          result_kind, frame_type, payload_byte,
//                                      payload_index, payload_count, checksum_ok
//
// one byte per cycle while rx_i.ready is high: the parse state updates in the cycle a byte is taken
// and its result (if any) sits in the output register on the next cycle.
// rx_i.ready is high whenever the output register is empty or being drained,
// so a stalled output blocks input only while a result is held.
// reset (rst_ni low, async) returns the parser to hunting with parse state and output valid cleared.
`default_nettype none

`include "sync_frame_parser_sum_check_macros.svh"

module sync_frame_parser_sum_check import sfpsc_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  sfpsc_rx_if.sink    rx_i,
  sfpsc_res_if.source res_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ByteW-1:0]  len_q, len_d;
  logic [ByteW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0]  type_q, type_d;

  logic              out_vld_q;
  logic              out_kind_q, out_kind_d;
  logic [ByteW-1:0]  out_type_q, out_type_d;
  logic [ByteW-1:0]  out_byte_q, out_byte_d;
  logic [ByteW-1:0]  out_idx_q, out_idx_d;
  logic [ByteW-1:0]  out_cnt_q, out_cnt_d;
  logic              out_ok_q, out_ok_d;
  logic              emit;

  logic              in_rdy;
  logic              in_acc;
  logic [ByteW-1:0]  b;
  logic [ByteW-1:0]  cnt_inc;

  assign in_rdy     = !out_vld_q || res_o.ready;
  assign rx_i.ready = in_rdy;
  assign in_acc     = rx_i.valid && in_rdy;
  assign b          = rx_i.rx_byte;
  assign cnt_inc    = cnt_q + 8'd1;

  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    type_d     = type_q;
    emit       = 1'b0;
    out_kind_d = KIND_PAYLOAD;
    out_type_d = type_q;
    out_byte_d = '0;
    out_idx_d  = '0;
    out_cnt_d  = '0;
    out_ok_d   = 1'b0;
    case (phase_q)
      PH_HUNT: begin
        if (b == SyncA) phase_d = PH_SYNC_B;
      end
      PH_SYNC_B: begin
        if (b == SyncB) begin
          phase_d = PH_SYNC_C;
        end else begin
          phase_d = PH_HUNT;
          len_d = '0; cnt_d = '0; sum_d = '0; type_d = '0;
        end
      end
      PH_SYNC_C: begin
        if (b == SyncC) begin
          phase_d = PH_LEN;
        end else begin
          phase_d = PH_HUNT;
          len_d = '0; cnt_d = '0; sum_d = '0; type_d = '0;
        end
      end
      PH_LEN: begin
        // zero length aborts the frame
        if (b == '0) begin
          phase_d = PH_HUNT;
          len_d = '0; cnt_d = '0; sum_d = '0; type_d = '0;
        end else begin
          len_d   = b;
          sum_d   = b;
          cnt_d   = '0;
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        sum_d  = sum_q + b;
        cnt_d  = 8'd1;
        type_d = b;
        // no-payload type or length one goes straight to the checksum
        if (b[NoPayloadBit] || len_q <= 8'd1) phase_d = PH_SUM;
        else phase_d = PH_DATA;
      end
      PH_DATA: begin
        sum_d      = sum_q + b;
        cnt_d      = cnt_inc;
        if (cnt_inc >= len_q) phase_d = PH_SUM;
        emit       = 1'b1;
        out_kind_d = KIND_PAYLOAD;
        out_byte_d = b;
        out_idx_d  = cnt_q - 8'd1;
      end
      PH_SUM: begin
        emit       = 1'b1;
        out_kind_d = KIND_END;
        out_cnt_d  = (cnt_q == '0) ? '0 : cnt_q - 8'd1;
        out_ok_d   = (sum_q == b);
        phase_d    = PH_HUNT;
        len_d = '0; cnt_d = '0; sum_d = '0; type_d = '0;
      end
      default: begin
        phase_d = PH_HUNT;
        len_d = '0; cnt_d = '0; sum_d = '0; type_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      type_q  <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      type_q  <= type_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_rdy) begin
      out_vld_q <= in_acc && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      out_kind_q <= out_kind_d;
      out_type_q <= out_type_d;
      out_byte_q <= out_byte_d;
      out_idx_q  <= out_idx_d;
      out_cnt_q  <= out_cnt_d;
      out_ok_q   <= out_ok_d;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.result_kind   = out_kind_q;
  assign res_o.frame_type    = out_type_q;
  assign res_o.payload_byte  = out_byte_q;
  assign res_o.payload_index = out_idx_q;
  assign res_o.payload_count = out_cnt_q;
  assign res_o.checksum_ok   = out_ok_q;

  // checksum byte always yields a frame-end result and returns to hunting
  `SFPSC_ASSERT(a_sum_ends_frame,
    in_acc && phase_q == PH_SUM |=> out_vld_q && out_kind_q == KIND_END && phase_q == PH_HUNT)
  // payload phase only leaves toward the checksum
  `SFPSC_ASSERT(a_data_exit,
    in_acc && phase_q == PH_DATA |=> phase_q == PH_DATA || phase_q == PH_SUM)
  // no result from sync, length or type bytes
  `SFPSC_ASSERT(a_no_hdr_result,
    in_acc && phase_q != PH_DATA && phase_q != PH_SUM |=> !out_vld_q)
  // an empty output register never blocks input
  `SFPSC_ASSERT_ALWAYS(a_ready_when_empty, !out_vld_q |-> rx_i.ready)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for the sync frame parser with additive checksum
`default_nettype none

module tb_top;
  import sfpsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] ftype;
    logic [ByteW-1:0] pbyte;
    logic [ByteW-1:0] pidx;
    logic [ByteW-1:0] pcount;
    logic             ok;
  } frame_res_t;

  logic clk_i;
  logic rst_ni;

  sfpsc_rx_if  rx_ch ();
  sfpsc_res_if res_ch ();

  sync_frame_parser_sum_check uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .res_o  (res_ch)
  );

  logic [ByteW-1:0] rx_bytes_q [$];
  frame_res_t       due_results [$];
  int unsigned      mismatches;
  int unsigned      results_seen;

  // parser copy kept by the testbench
  logic [PhaseW-1:0] p_phase;
  logic [ByteW-1:0]  p_len;
  logic [ByteW-1:0]  p_cnt;
  logic [ByteW-1:0]  p_sum;
  logic [ByteW-1:0]  p_type;

  bit          tx_calm;
  bit          rx_calm;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned hold_left;
  bit          hold_done;

  function automatic void clear_parser();
    p_phase = PH_HUNT;
    p_len   = '0;
    p_cnt   = '0;
    p_sum   = '0;
    p_type  = '0;
  endfunction

  function automatic void parse_byte(input logic [ByteW-1:0] b, output bit hit,
                                     output frame_res_t r);
    hit = 1'b0;
    r   = '0;
    case (p_phase)
      PH_HUNT: begin
        if (b == SyncA) p_phase = PH_SYNC_B;
      end
      PH_SYNC_B: begin
        if (b == SyncB) p_phase = PH_SYNC_C;
        else clear_parser();
      end
      PH_SYNC_C: begin
        if (b == SyncC) p_phase = PH_LEN;
        else clear_parser();
      end
      PH_LEN: begin
        if (b == '0) begin
          clear_parser();
        end else begin
          p_len   = b;
          p_sum   = b;
          p_cnt   = '0;
          p_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        p_sum   = p_sum + b;
        p_cnt   = 8'd1;
        p_type  = b;
        p_phase = (b[NoPayloadBit] || p_len <= 8'd1) ? PH_SUM : PH_DATA;
      end
      PH_DATA: begin
        r.kind  = KIND_PAYLOAD;
        r.ftype = p_type;
        r.pbyte = b;
        r.pidx  = p_cnt - 8'd1;
        hit     = 1'b1;
        p_sum   = p_sum + b;
        p_cnt   = p_cnt + 8'd1;
        if (p_cnt >= p_len) p_phase = PH_SUM;
      end
      PH_SUM: begin
        r.kind   = KIND_END;
        r.ftype  = p_type;
        r.pcount = (p_cnt == '0) ? 8'd0 : p_cnt - 8'd1;
        r.ok     = (p_sum == b);
        hit      = 1'b1;
        clear_parser();
      end
      default: clear_parser();
    endcase
  endfunction

  // mostly short gaps, a few long ones, none while calm
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic push_frame(input logic [ByteW-1:0] len, input logic [ByteW-1:0] ftype,
                            input bit good_sum);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    rx_bytes_q.push_back(SyncA);
    rx_bytes_q.push_back(SyncB);
    rx_bytes_q.push_back(SyncC);
    rx_bytes_q.push_back(len);
    if (len == '0) return;
    rx_bytes_q.push_back(ftype);
    sum = len + ftype;
    if (!ftype[NoPayloadBit] && len > 8'd1) begin
      for (int i = 1; i < int'(len); i++) begin
        b = 8'($urandom);
        rx_bytes_q.push_back(b);
        sum = sum + b;
      end
    end
    if (good_sum) rx_bytes_q.push_back(sum);
    else rx_bytes_q.push_back(sum ^ 8'($urandom_range(1, 255)));
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) tx_calm <= ~tx_calm;
    if ($urandom_range(0, 299) == 0) rx_calm <= ~rx_calm;
  end

  // sender: one item per free slot, gap chosen after each item
  always @(posedge clk_i or negedge rst_ni) begin
    bit         hit;
    frame_res_t r;
    if (!rst_ni) begin
      rx_ch.valid   <= 1'b0;
      rx_ch.rx_byte <= '0;
      tx_gap        <= 0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        parse_byte(rx_ch.rx_byte, hit, r);
        if (hit) due_results.push_back(r);
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if (tx_gap != 0) begin
          rx_ch.valid <= 1'b0;
          tx_gap      <= tx_gap - 1;
        end else if (rx_bytes_q.size() != 0) begin
          rx_ch.valid   <= 1'b1;
          rx_ch.rx_byte <= rx_bytes_q.pop_front();
          // keep offering while the receiver is held off
          tx_gap        <= (hold_left != 0) ? 0 : pick_gap(tx_calm);
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result and throttles ready
  always @(posedge clk_i or negedge rst_ni) begin
    frame_res_t got;
    frame_res_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      rx_gap       <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{kind: res_ch.result_kind, ftype: res_ch.frame_type,
                pbyte: res_ch.payload_byte, pidx: res_ch.payload_index,
                pcount: res_ch.payload_count, ok: res_ch.checksum_ok};
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d type=%02h", got.kind,
                                    got.ftype));
        end else begin
          want = due_results.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              "got %0d/%02h/%02h/%0d/%0d/%0d want %0d/%02h/%02h/%0d/%0d/%0d",
              got.kind, got.ftype, got.pbyte, got.pidx, got.pcount, got.ok,
              want.kind, want.ftype, want.pbyte, want.pidx, want.pcount, want.ok));
        end
      end
      if (!hold_done && results_seen == 150) begin
        // long back-pressure so the output register fills and input stalls
        hold_done    <= 1'b1;
        hold_left    <= 400;
        res_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        res_ch.ready <= (hold_left == 1);
      end else if (rx_gap != 0) begin
        res_ch.ready <= 1'b0;
        rx_gap       <= rx_gap - 1;
      end else begin
        res_ch.ready <= 1'b1;
        rx_gap       <= pick_gap(rx_calm);
      end
    end
  end

  initial begin
    logic [ByteW-1:0] directed [0:28];
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] ftype;
    int unsigned      r;

    rst_ni = 1'b0;
    clear_parser();

    // payload extremes, no-payload type, length one with bad checksum,
    // length zero abort, bad third sync, bad second sync that is a sync byte
    directed = '{SyncA, SyncB, SyncC, 8'h03, 8'h01, 8'h00, 8'hFF, 8'h03,
                 SyncA, SyncB, SyncC, 8'h05, 8'h80, 8'h85,
                 SyncA, SyncB, SyncC, 8'h01, 8'h7F, 8'h00,
                 SyncA, SyncB, SyncC, 8'h00,
                 SyncA, SyncB, SyncA,
                 SyncA, SyncA};
    foreach (directed[i]) rx_bytes_q.push_back(directed[i]);

    while (rx_bytes_q.size() < 2000) begin
      r = $urandom_range(0, 99);
      if (r < 82) begin
        r = $urandom_range(0, 99);
        if (r < 60) len = 8'($urandom_range(1, 8));
        else if (r < 75) len = 8'($urandom_range(9, 40));
        else if (r < 82) len = 8'($urandom_range(0, 1));
        else if (r < 85) len = 8'd255;
        else len = 8'($urandom_range(41, 254));
        ftype = {($urandom_range(0, 3) == 0), 7'($urandom)};
        push_frame(len, ftype, $urandom_range(0, 9) != 0);
      end else if (r < 91) begin
        repeat ($urandom_range(1, 6)) rx_bytes_q.push_back(8'($urandom));
      end else begin
        // broken sync sequence
        rx_bytes_q.push_back(SyncA);
        if ($urandom_range(0, 1) != 0) rx_bytes_q.push_back(SyncB);
        rx_bytes_q.push_back(8'($urandom));
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (rx_bytes_q.size() != 0 || rx_ch.valid || due_results.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
